@@ rtl/sstat_pkg.sv @@
// Shared types and constants for the sample store with running statistics.
// Holds the buffer geometry, the mode codes, the command record passed from
// the front part to the back part, and the back part's state encoding.
`default_nettype none

package sstat_pkg;

    localparam int CAPACITY    = 128;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int SUM_W       = 32 + $clog2(CAPACITY);
    localparam int ENTRY_IDX_W = 7;
    localparam int COUNT_OUT_W = 8;
    localparam int CMP_W       = (CNT_W > ENTRY_IDX_W) ? CNT_W : ENTRY_IDX_W;
    localparam int WORD_W      = 32 + 32 + 8;
    localparam int STEP_W      = $clog2(SUM_W + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_APPEND    = 2'd0,
        MODE_CLEAR     = 2'd1,
        MODE_READ_AT   = 2'd2,
        MODE_READ_LAST = 2'd3
    } mode_t;

    // One classified item: what the back part must write, what it must read,
    // and the statistics state as it stands after the item.
    typedef struct packed {
        logic                    wr_en;
        logic [IDX_W-1:0]        wr_addr;
        logic [31:0]             wr_time;
        logic signed [31:0]      wr_value;
        logic [7:0]              wr_status;
        logic                    rd_found;
        logic [IDX_W-1:0]        rd_addr;
        logic                    accepted;
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum;
        logic signed [31:0]      least;
        logic signed [31:0]      greatest;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/sstat_sample_if.sv @@
// Input channel of the sample store: valid/ready handshake plus one sample item.
// Depends on sstat_pkg for the entry index width.
`default_nettype none

interface sstat_sample_if import sstat_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              mode;
    logic [31:0]             sample_time;
    logic signed [31:0]      sample_value;
    logic [7:0]              sample_status;
    logic [ENTRY_IDX_W-1:0]  entry_index;

    modport source (
        output valid, mode, sample_time, sample_value, sample_status, entry_index,
        input  ready
    );

    modport sink (
        input  valid, mode, sample_time, sample_value, sample_status, entry_index,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/sstat_result_if.sv @@
// Output channel of the sample store: valid/ready handshake plus one result item.
// Depends on sstat_pkg for the count width.
`default_nettype none

interface sstat_result_if import sstat_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    accepted;
    logic [COUNT_OUT_W-1:0]  sample_count;
    logic signed [31:0]      mean_value;
    logic signed [31:0]      least_value;
    logic signed [31:0]      greatest_value;
    logic                    entry_found;
    logic [31:0]             entry_time;
    logic signed [31:0]      entry_value;
    logic [7:0]              entry_status;

    modport source (
        output valid, accepted, sample_count, mean_value, least_value, greatest_value,
               entry_found, entry_time, entry_value, entry_status,
        input  ready
    );

    modport sink (
        input  valid, accepted, sample_count, mean_value, least_value, greatest_value,
               entry_found, entry_time, entry_value, entry_status,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/sample_store_with_statistics.sv @@
// Top level of the sample store with running statistics.
// Depends on sstat_pkg, sstat_sample_if, sstat_result_if, sstat_front,
// sstat_queue and sstat_back.
`default_nettype none

// A fill-once store of up to CAPACITY timestamped samples that answers every
// item with the count and the mean, minimum and maximum of the stored values,
// plus the entry read in the two read modes. The front part updates count,
// sum, minimum and maximum as each item is accepted and queues a command; the
// back part writes or reads the sample memory and divides the sum by the count
// one quotient bit per cycle in a bit-serial divider; the two-entry command
// queue lets the front part keep taking items while the back part works and
// the result register waits for its transfer. The sample memory needs no
// clearing after reset, since reads are limited to held entries.
module sample_store_with_statistics import sstat_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    sstat_sample_if.sink   samples,
    sstat_result_if.source results
);

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    sstat_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    sstat_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    sstat_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .results    (results)
    );

    // An empty store reports zero statistics.
    a_empty_stats_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.sample_count == '0) |->
        (results.mean_value == 0) && (results.least_value == 0) &&
        (results.greatest_value == 0))
        else $error("empty store reports nonzero statistics");

    // Entry fields are zero whenever no entry was found.
    a_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.entry_found |->
        (results.entry_time == '0) && (results.entry_value == 0) &&
        (results.entry_status == '0))
        else $error("entry fields nonzero without a found entry");

    // A stored append is never a read, always leaves at least one sample and gives a mean between minimum and maximum.
    a_append_result: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.accepted |->
        !results.entry_found && (results.sample_count != '0) &&
        (results.least_value <= results.mean_value) &&
        (results.mean_value <= results.greatest_value))
        else $error("inconsistent result for a stored append");

    // The back part only takes a command that the queue holds.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("command popped from an empty queue");

endmodule

`default_nettype wire

@@ rtl/sstat_front.sv @@
// Front part: takes sample items, keeps count, running sum, minimum and maximum,
// and hands a classified command to the queue. Depends on sstat_pkg, sstat_sample_if.
`default_nettype none

module sstat_front import sstat_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    sstat_sample_if.sink      samples,
    input  wire logic         q_full,
    output logic              push,
    output cmd_t              push_cmd
);

    logic [CNT_W-1:0]        count_reg,    count_next;
    logic signed [SUM_W-1:0] sum_reg,      sum_next;
    logic signed [31:0]      least_reg,    least_next;
    logic signed [31:0]      greatest_reg, greatest_next;

    logic                    full;
    logic signed [SUM_W-1:0] value_ext;
    mode_t                   mode;

    assign samples.ready = !q_full;
    assign push          = samples.valid && !q_full;

    assign mode      = mode_t'(samples.mode);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign value_ext = SUM_W'(samples.sample_value);

    always_comb
    begin
        count_next    = count_reg;
        sum_next      = sum_reg;
        least_next    = least_reg;
        greatest_next = greatest_reg;

        push_cmd           = '0;
        push_cmd.wr_addr   = count_reg[IDX_W-1:0];
        push_cmd.wr_time   = samples.sample_time;
        push_cmd.wr_value  = samples.sample_value;
        push_cmd.wr_status = samples.sample_status;

        case (mode)
            MODE_APPEND:
            begin
                if (!full)
                begin
                    push_cmd.wr_en    = 1'b1;
                    push_cmd.accepted = 1'b1;
                    if (count_reg == '0)
                    begin
                        least_next    = samples.sample_value;
                        greatest_next = samples.sample_value;
                    end
                    else
                    begin
                        if (samples.sample_value < least_reg)
                        begin
                            least_next = samples.sample_value;
                        end
                        if (samples.sample_value > greatest_reg)
                        begin
                            greatest_next = samples.sample_value;
                        end
                    end
                    sum_next   = sum_reg + value_ext;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_CLEAR:
            begin
                count_next    = '0;
                sum_next      = '0;
                least_next    = '0;
                greatest_next = '0;
            end
            MODE_READ_AT:
            begin
                if ((CMP_W'(samples.entry_index) < CMP_W'(count_reg)) &&
                    (CMP_W'(samples.entry_index) < CMP_W'(CAPACITY)))
                begin
                    push_cmd.rd_found = 1'b1;
                    push_cmd.rd_addr  = IDX_W'(samples.entry_index);
                end
            end
            MODE_READ_LAST:
            begin
                if (count_reg != '0)
                begin
                    push_cmd.rd_found = 1'b1;
                    push_cmd.rd_addr  = IDX_W'(count_reg - 1'b1);
                end
            end
            default:
            begin
            end
        endcase

        push_cmd.count    = count_next;
        push_cmd.sum      = sum_next;
        push_cmd.least    = least_next;
        push_cmd.greatest = greatest_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_reg      <= '0;
            least_reg    <= '0;
            greatest_reg <= '0;
        end
        else if (push)
        begin
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            least_reg    <= least_next;
            greatest_reg <= greatest_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sstat_queue.sv @@
// Short command queue between the front and back parts, so either side can stall.
// Depends on sstat_pkg for the command record and queue depth.
`default_nettype none

module sstat_queue import sstat_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire cmd_t  push_cmd,
    output logic       full,
    input  wire logic  pop,
    output logic       head_valid,
    output cmd_t       head_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg,   fill_next;

    assign full       = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sstat_back.sv @@
// Back part: sample memory, bit-serial mean divider and the result register.
// Depends on sstat_pkg and sstat_result_if.
`default_nettype none

module sstat_back import sstat_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      head_valid,
    input  wire cmd_t      head_cmd,
    output logic           pop,
    sstat_result_if.source results
);

    back_state_t             state_reg, state_next;

    logic [WORD_W-1:0]       mem [CAPACITY];
    logic [WORD_W-1:0]       rd_data_reg;
    cmd_t                    cmd_reg;
    logic [SUM_W-1:0]        quo_reg;
    logic [CNT_W:0]          rem_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    neg_reg;

    logic                    out_valid_reg;
    logic                    out_accepted_reg;
    logic [COUNT_OUT_W-1:0]  out_count_reg;
    logic signed [31:0]      out_mean_reg;
    logic signed [31:0]      out_least_reg;
    logic signed [31:0]      out_greatest_reg;
    logic                    out_found_reg;
    logic [31:0]             out_time_reg;
    logic signed [31:0]      out_value_reg;
    logic [7:0]              out_status_reg;

    logic                    div_step;
    logic                    load_out;
    logic                    out_free;
    logic [SUM_W-1:0]        sum_mag;
    logic [CNT_W:0]          rem_shift;
    logic [CNT_W:0]          divisor;
    logic                    quo_bit;
    logic [SUM_W-1:0]        mean_full;

    assign out_free = !out_valid_reg || results.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (step_reg == STEP_W'(1))
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        pop      = 1'b0;
        div_step = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                pop = head_valid;
            end
            BK_DIV:
            begin
                div_step = 1'b1;
            end
            BK_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // Restoring division of the sum magnitude by the count, one bit per cycle.
    assign sum_mag   = head_cmd.sum[SUM_W-1] ? SUM_W'(-head_cmd.sum) : SUM_W'(head_cmd.sum);
    assign rem_shift = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
    assign divisor   = {1'b0, cmd_reg.count};
    assign quo_bit   = (rem_shift >= divisor);
    assign mean_full = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg  <= head_cmd;
            quo_reg  <= sum_mag;
            rem_reg  <= '0;
            step_reg <= STEP_W'(SUM_W);
            neg_reg  <= head_cmd.sum[SUM_W-1];
        end
        else if (div_step)
        begin
            quo_reg  <= {quo_reg[SUM_W-2:0], quo_bit};
            rem_reg  <= quo_bit ? (rem_shift - divisor) : rem_shift;
            step_reg <= step_reg - 1'b1;
        end
    end

    // Sample memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (pop && head_cmd.wr_en)
        begin
            mem[head_cmd.wr_addr] <= {head_cmd.wr_time, head_cmd.wr_value, head_cmd.wr_status};
        end
        if (pop && head_cmd.rd_found)
        begin
            rd_data_reg <= mem[head_cmd.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_accepted_reg <= cmd_reg.accepted;
            out_count_reg    <= COUNT_OUT_W'(cmd_reg.count);
            out_least_reg    <= cmd_reg.least;
            out_greatest_reg <= cmd_reg.greatest;
            out_found_reg    <= cmd_reg.rd_found;
            if (cmd_reg.count == '0)
            begin
                out_mean_reg <= '0;
            end
            else
            begin
                out_mean_reg <= signed'(mean_full[31:0]);
            end
            if (cmd_reg.rd_found)
            begin
                out_time_reg   <= rd_data_reg[WORD_W-1 -: 32];
                out_value_reg  <= signed'(rd_data_reg[WORD_W-33 -: 32]);
                out_status_reg <= rd_data_reg[7:0];
            end
            else
            begin
                out_time_reg   <= '0;
                out_value_reg  <= '0;
                out_status_reg <= '0;
            end
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.accepted       = out_accepted_reg;
    assign results.sample_count   = out_count_reg;
    assign results.mean_value     = out_mean_reg;
    assign results.least_value    = out_least_reg;
    assign results.greatest_value = out_greatest_reg;
    assign results.entry_found    = out_found_reg;
    assign results.entry_time     = out_time_reg;
    assign results.entry_value    = out_value_reg;
    assign results.entry_status   = out_status_reg;

endmodule

`default_nettype wire
